### rtl/sfod_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and register codes of the spectral flux onset detector.
package sfod_pkg;

    localparam int MAX_BINS   = 1024;
    localparam int BIN_W      = $clog2(MAX_BINS);
    localparam int FILL_W     = $clog2(MAX_BINS + 1);

    localparam int POWER_W    = 24;
    localparam int FLUX_W     = 34;
    localparam int MULT_W     = 10;
    localparam int COOL_W     = 4;
    localparam int FRAC_W     = 8;
    localparam int PROD_W     = FLUX_W + MULT_W;
    localparam int CMP_W      = PROD_W + 1;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 40;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam int SMOOTH_W   = FLUX_W + FRAC_W + 1;
    localparam logic [FRAC_W-1:0] SMOOTH_OLD = 8'd205;
    localparam logic [FRAC_W-1:0] SMOOTH_NEW = 8'd51;

    localparam logic [FLUX_W-1:0] FLUX_MAX = {FLUX_W{1'b1}};

    localparam logic [MULT_W-1:0]  MULT_RESET  = 10'd640;
    localparam logic [POWER_W-1:0] NOISE_RESET = '0;
    localparam logic [COOL_W-1:0]  COOL_RESET  = 4'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MULT     = 2'd0,
        CFG_NOISE    = 2'd1,
        CFG_COOLDOWN = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [MULT_W-1:0]  mult;
        logic [POWER_W-1:0] noise;
        logic [COOL_W-1:0]  cooldown;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic [FLUX_W-1:0] flux;
    } frame_req_t;

endpackage

### rtl/spectral_flux_onset_detector.sv
`timescale 1ns / 1ps
// Top level of the spectral flux onset detector.
//
//  channel | direction | signals                        | contents
//  --------+-----------+--------------------------------+-------------------------------
//  s_      | in        | s_tvalid s_tready s_tdata s_tlast | bin power; tlast ends frame
//  m_      | out       | m_tvalid m_tready m_tdata m_tuser | frame flux; tuser is onset
//  cfg_    | in        | cfg_valid cfg_ready cfg_index cfg_wdata | register writes
//
//  One bin per cycle while s_tready is high; the RAM read-modify-write pipeline sets that rate.
//  A frame result passes the s1, e2 and output registers after its last bin is taken.
//  A one-bin frame right after another frame end stalls the s_ side while the
//  threshold product is rebuilt from the new smoothed flux.
//  Reset needs no clearing pass: a fill count marks unwritten bins as zero.
//  A stalled m_ side holds at most one more frame result before s_tready drops.
module spectral_flux_onset_detector (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sfod_pkg::IN_DATA_W-1:0]  s_tdata,   // [23:0] power
    input  logic                            s_tlast,   // last_bin
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sfod_pkg::OUT_DATA_W-1:0] m_tdata,   // [33:0] frame_flux, [39:34] zero
    output logic                            m_tuser,   // [0] onset
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sfod_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfod_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import sfod_pkg::*;

    cfg_t               cfg_reg;
    cfg_t               cfg_next;
    logic [BIN_W-1:0]   bin_pos_reg;
    logic [BIN_W-1:0]   bin_pos_next;
    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic [POWER_W-1:0] s1_power_reg;
    logic [BIN_W-1:0]   s1_idx_reg;
    logic               s1_last_reg;
    logic [FLUX_W-1:0]  flux_reg;
    logic [FLUX_W-1:0]  flux_next;

    logic               accept;
    logic               s1_adv;
    logic               frame_ready;
    logic [POWER_W-1:0] prev_power;
    logic [POWER_W-1:0] diff;
    logic [FLUX_W:0]    flux_sum;
    logic [FLUX_W-1:0]  flux_new;
    frame_req_t         frame;

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign s1_adv    = !s1_valid_reg || !s1_last_reg || frame_ready;
    assign s_tready  = s1_adv;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MULT:     cfg_next.mult     = cfg_wdata[MULT_W-1:0];
                CFG_NOISE:    cfg_next.noise    = cfg_wdata[POWER_W-1:0];
                CFG_COOLDOWN: cfg_next.cooldown = cfg_wdata[COOL_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        bin_pos_next = bin_pos_reg;
        if (accept) begin
            priority if (s_tlast) begin
                bin_pos_next = '0;
            end else if (bin_pos_reg == BIN_W'(MAX_BINS - 1)) begin
                bin_pos_next = '0;
            end else begin
                bin_pos_next = bin_pos_reg + 1'b1;
            end
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s1_adv) begin
            s1_valid_next = accept;
        end
    end

    sfod_bin_store u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rd_en      (accept),
        .rd_addr    (bin_pos_reg),
        .wr_en      (s1_valid_reg && s1_adv),
        .wr_addr    (s1_idx_reg),
        .wr_data    (s1_power_reg),
        .prev_power (prev_power)
    );

    assign diff     = (s1_power_reg > prev_power) ? (s1_power_reg - prev_power) : '0;
    assign flux_sum = (FLUX_W + 1)'(flux_reg) + (FLUX_W + 1)'(diff);
    assign flux_new = flux_sum[FLUX_W] ? FLUX_MAX : flux_sum[FLUX_W-1:0];

    always_comb begin
        flux_next = flux_reg;
        if (s1_valid_reg && s1_adv) begin
            flux_next = s1_last_reg ? '0 : flux_new;
        end
    end

    assign frame.valid = s1_valid_reg && s1_last_reg;
    assign frame.flux  = flux_new;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mult     <= MULT_RESET;
            cfg_reg.noise    <= NOISE_RESET;
            cfg_reg.cooldown <= COOL_RESET;
            bin_pos_reg      <= '0;
            s1_valid_reg     <= 1'b0;
            flux_reg         <= '0;
        end else begin
            cfg_reg      <= cfg_next;
            bin_pos_reg  <= bin_pos_next;
            s1_valid_reg <= s1_valid_next;
            flux_reg     <= flux_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_power_reg <= s_tdata[POWER_W-1:0];
            s1_idx_reg   <= bin_pos_reg;
            s1_last_reg  <= s_tlast;
        end
    end

    sfod_frame_eval u_eval (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .frame       (frame),
        .frame_ready (frame_ready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

### rtl/sfod_bin_store.sv
`timescale 1ns / 1ps
// Previous-frame power store: synchronous RAM with fill count and write forwarding.
module sfod_bin_store (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         rd_en,
    input  logic [sfod_pkg::BIN_W-1:0]   rd_addr,
    input  logic                         wr_en,
    input  logic [sfod_pkg::BIN_W-1:0]   wr_addr,
    input  logic [sfod_pkg::POWER_W-1:0] wr_data,
    output logic [sfod_pkg::POWER_W-1:0] prev_power
);
    import sfod_pkg::*;

    logic [POWER_W-1:0] mem [MAX_BINS];
    logic [POWER_W-1:0] rd_data_reg;
    logic [POWER_W-1:0] fwd_data_reg;
    logic               fwd_reg;
    logic               hit_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            fwd_reg      <= wr_en && (wr_addr == rd_addr);
            fwd_data_reg <= wr_data;
            hit_reg      <= (FILL_W'(rd_addr) < fill_reg);
        end
    end

    always_comb begin
        fill_next = fill_reg;
        if (wr_en && (FILL_W'(wr_addr) >= fill_reg)) begin
            fill_next = FILL_W'(wr_addr) + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    always_comb begin
        priority if (fwd_reg) begin
            prev_power = fwd_data_reg;
        end else if (hit_reg) begin
            prev_power = rd_data_reg;
        end else begin
            prev_power = '0;
        end
    end

endmodule

### rtl/sfod_frame_eval.sv
`timescale 1ns / 1ps
// Frame-end stage: threshold test, cooldown, flux smoothing and result register.
module sfod_frame_eval (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  sfod_pkg::cfg_t                  cfg,
    input  sfod_pkg::frame_req_t            frame,
    output logic                            frame_ready,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sfod_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                            m_tuser
);
    import sfod_pkg::*;

    logic               e2_valid_reg;
    logic               e2_valid_next;
    logic [FLUX_W-1:0]  e2_flux_reg;
    logic [FLUX_W-1:0]  smooth_reg;
    logic [FLUX_W-1:0]  smooth_next;
    logic [PROD_W-1:0]  prod_reg;
    logic               stale_reg;
    logic [COOL_W-1:0]  cool_reg;
    logic [COOL_W-1:0]  cool_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_onset_reg;
    logic [FLUX_W-1:0]  out_flux_reg;

    logic               e2_adv;
    logic               onset;
    logic [CMP_W-1:0]   lhs;
    logic [CMP_W-1:0]   rhs;
    logic [SMOOTH_W-1:0] smooth_sum;
    logic [SMOOTH_W-FRAC_W-1:0] smooth_shift;

    assign e2_adv      = e2_valid_reg && !stale_reg && (!out_valid_reg || m_tready);
    assign frame_ready = !e2_valid_reg || e2_adv;

    assign lhs   = CMP_W'({e2_flux_reg, {FRAC_W{1'b0}}});
    assign rhs   = CMP_W'(prod_reg) + CMP_W'({cfg.noise, {FRAC_W{1'b0}}});
    assign onset = (cool_reg == '0) && (lhs > rhs);

    assign smooth_sum   = SMOOTH_W'(smooth_reg) * SMOOTH_W'(SMOOTH_OLD)
                        + SMOOTH_W'(e2_flux_reg) * SMOOTH_W'(SMOOTH_NEW);
    assign smooth_shift = smooth_sum[SMOOTH_W-1:FRAC_W];

    always_comb begin
        e2_valid_next = e2_valid_reg;
        if (frame_ready) begin
            e2_valid_next = frame.valid;
        end
    end

    always_comb begin
        smooth_next = smooth_reg;
        cool_next   = cool_reg;
        if (e2_adv) begin
            smooth_next = (smooth_shift > (SMOOTH_W - FRAC_W)'(FLUX_MAX))
                        ? FLUX_MAX : smooth_shift[FLUX_W-1:0];
            if (cool_reg != '0) begin
                cool_next = cool_reg - 1'b1;
            end else if (onset) begin
                cool_next = cfg.cooldown;
            end
        end
    end

    always_comb begin
        priority if (e2_adv) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e2_valid_reg  <= 1'b0;
            smooth_reg    <= '0;
            stale_reg     <= 1'b1;
            cool_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            e2_valid_reg  <= e2_valid_next;
            smooth_reg    <= smooth_next;
            stale_reg     <= e2_adv;
            cool_reg      <= cool_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(smooth_reg) * PROD_W'(cfg.mult);
        if (frame_ready && frame.valid) begin
            e2_flux_reg <= frame.flux;
        end
        if (e2_adv) begin
            out_onset_reg <= onset;
            out_flux_reg  <= e2_flux_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_flux_reg);
    assign m_tuser  = out_onset_reg;

endmodule

### rtl/sfod_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the spectral flux onset detector, bound to the top level.
module sfod_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [sfod_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                            m_tuser
);
    import sfod_pkg::*;

    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[OUT_DATA_W-1:FLUX_W] == '0))
        else $error("result padding not zero");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready) |=> !(m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                     && m_tuser && (m_tdata == '0)))
        else $error("onset reported with zero flux twice in a row");

endmodule

bind spectral_flux_onset_detector sfod_checker u_sfod_checker (.*);
